// ===== design/slfp_pkg.sv =====
`timescale 1ns / 1ps

package slfp_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_OK      = 2'd1;
    localparam t_kind KIND_BADSUM  = 2'd2;
    localparam t_kind KIND_LENERR  = 2'd3;

    localparam logic [7:0]  SYNC_FIRST   = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND  = 8'hFE;
    localparam logic [31:0] HDR_OVERHEAD = 32'd4;
    localparam logic [31:0] MAX_LEN_RST  = 32'hFFFF_FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] command;
        logic [31:0] payload_count;
    } t_result;

endpackage

// ===== design/slfp_in_if.sv =====
`timescale 1ns / 1ps

interface slfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/slfp_out_if.sv =====
`timescale 1ns / 1ps

interface slfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] command;
    logic [31:0] payload_count;

    modport source (output valid, output kind, output payload_byte, output command,
                    output payload_count, input ready);
    modport sink   (input valid, input kind, input payload_byte, input command,
                    input payload_count, output ready);
endinterface

// ===== design/sync_length_frame_parser.sv =====
`timescale 1ns / 1ps
// Sync/length/checksum deframer for a byte stream.
// i_in  : one stream byte per transfer (valid/ready).
// o_out : results (valid/ready): payload bytes, frame ok, checksum mismatch,
//         or length error; others carry the frame's command and payload count.
// Frame: FF FE, 32-bit LE length, 16-bit LE command, length-4 payload bytes,
//        16-bit LE byte-sum checksum of the payload.
// i_cfg_we/i_cfg_wdata write max_length (reset 0xFFFFFFFF); write while idle.
// Latency: a result appears on o_out the cycle after the byte that causes it
// is transferred. Throughput: one byte per cycle unless o_out stalls; parser
// state and result update together; one output register holds the result.
// Stall: i_in.ready drops only while the output register holds a result the
// receiver has not taken; a byte can be taken in the same cycle the held
// result is transferred.
// Reset (synchronous, active low): hunting for sync, no result pending,
// max_length back to 0xFFFFFFFF.
module sync_length_frame_parser
    import slfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    slfp_in_if.sink     i_in,
    slfp_out_if.source  o_out
);

    logic [31:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;

    logic        in_accept;
    logic        res_valid;
    t_result     res;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    slfp_deframer u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte       (i_in.in_byte),
        .i_max_length (r_max_len),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.command       = r_out.command;
    assign o_out.payload_count = r_out.payload_count;

    a_no_result_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> !res_valid)
        else $error("result produced without a byte transfer");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("byte taken while a result is stalled");

    a_lenerr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_LENERR |->
            r_out.command == 16'd0 && r_out.payload_count == 32'd0)
        else $error("length error carries command or count");

    a_payload_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != KIND_PAYLOAD |-> r_out.payload_byte == 8'd0)
        else $error("non-payload result carries a payload byte");

endmodule

// ===== design/slfp_deframer.sv =====
`timescale 1ns / 1ps

module slfp_deframer
    import slfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_length,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic        r_prev_ff, n_prev_ff;
    logic [1:0]  r_idx,    n_idx;
    logic [31:0] r_len,    n_len;
    logic [15:0] r_cmd,    n_cmd;
    logic [31:0] r_left,   n_left;
    logic [31:0] r_count,  n_count;
    logic [15:0] r_sum,    n_sum;
    logic [7:0]  r_sum_lo, n_sum_lo;

    logic [31:0] full_len;

    always_comb begin
        n_phase     = r_phase;
        n_prev_ff   = r_prev_ff;
        n_idx       = r_idx;
        n_len       = r_len;
        n_cmd       = r_cmd;
        n_left      = r_left;
        n_count     = r_count;
        n_sum       = r_sum;
        n_sum_lo    = r_sum_lo;
        full_len    = {i_byte, r_len[23:0]};
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (r_prev_ff && i_byte == SYNC_SECOND) begin
                    n_phase   = PH_LEN;
                    n_idx     = 2'd0;
                    n_len     = '0;
                    n_prev_ff = 1'b0;
                end else begin
                    n_prev_ff = (i_byte == SYNC_FIRST);
                end
            end
            PH_LEN: begin
                unique case (r_idx)
                    2'd0: n_len = {r_len[31:8], i_byte};
                    2'd1: n_len = {r_len[31:16], i_byte, r_len[7:0]};
                    2'd2: n_len = {r_len[31:24], i_byte, r_len[15:0]};
                    default: n_len = full_len;
                endcase
                if (r_idx != 2'd3) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx = 2'd0;
                    if (full_len < HDR_OVERHEAD || full_len > i_max_length) begin
                        n_phase     = PH_HUNT;
                        n_prev_ff   = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_LENERR;
                    end else begin
                        n_phase = PH_CMD;
                        n_cmd   = '0;
                    end
                end
            end
            PH_CMD: begin
                if (r_idx == 2'd0) begin
                    n_cmd = {8'h00, i_byte};
                    n_idx = 2'd1;
                end else begin
                    n_cmd   = {i_byte, r_cmd[7:0]};
                    n_idx   = 2'd0;
                    n_left  = r_len - HDR_OVERHEAD;
                    n_count = '0;
                    n_sum   = '0;
                    n_phase = (r_len == HDR_OVERHEAD) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum               = r_sum + {8'h00, i_byte};
                n_left              = r_left - 32'd1;
                n_count             = r_count + 32'd1;
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.command       = r_cmd;
                o_res.payload_count = n_count;
                if (r_left == 32'd1) begin
                    n_phase = PH_SUM;
                    n_idx   = 2'd0;
                end
            end
            PH_SUM: begin
                if (r_idx == 2'd0) begin
                    n_sum_lo = i_byte;
                    n_idx    = 2'd1;
                end else begin
                    n_phase             = PH_HUNT;
                    n_prev_ff           = 1'b0;
                    n_idx               = 2'd0;
                    o_res_valid         = 1'b1;
                    o_res.kind          = ({i_byte, r_sum_lo} == r_sum) ? KIND_OK
                                                                        : KIND_BADSUM;
                    o_res.command       = r_cmd;
                    o_res.payload_count = r_count;
                end
            end
            default: begin
                n_phase   = PH_HUNT;
                n_prev_ff = 1'b0;
                n_idx     = 2'd0;
            end
        endcase

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_prev_ff <= 1'b0;
            r_idx     <= '0;
            r_len     <= '0;
            r_cmd     <= '0;
            r_left    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_sum_lo  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_prev_ff <= n_prev_ff;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_cmd     <= n_cmd;
            r_left    <= n_left;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_sum_lo  <= n_sum_lo;
        end
    end

endmodule
